@@ sv/lift_endstop_timeout_controller_defines.svh @@
// ----------------------------------------------------------------------------
// Lift end-stop controller assertion macros
// Shared assertion forms used by the lift controller top level.
// ----------------------------------------------------------------------------
`ifndef LIFT_ENDSTOP_TIMEOUT_CONTROLLER_DEFINES_SVH
`define LIFT_ENDSTOP_TIMEOUT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LETC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LETC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/letc_pkg.sv @@
// ----------------------------------------------------------------------------
// Lift end-stop controller package
// Payload types, command codes and reset values shared by the lift controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package letc_pkg;

  typedef enum logic [1:0] {
    ACT_STEP   = 2'd0,
    ACT_MOVE   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_ENABLE = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_STOP = 2'd2
  } cmd_e;

  typedef enum logic {
    CFG_DUTY    = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_idx_e;

  localparam logic POS_UP   = 1'b0;
  localparam logic POS_DOWN = 1'b1;

  localparam int unsigned DutyW    = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned FailW    = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DutyW-1:0]    DutyReset    = 8'd8;
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd1000;
  localparam logic [FailW-1:0]    FailLimit    = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic             target;
    logic             enable;
    logic             up_contact;
    logic             down_contact;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [1:0]       motor_command;
    logic             motor_direction;
    logic [DutyW-1:0] motor_duty;
    logic             lift_position;
    logic             is_moving;
    logic             control_on;
    logic [FailW-1:0] failure_count;
  } result_t;

  typedef struct packed {
    logic [DutyW-1:0]    duty_level;
    logic [TimeoutW-1:0] timeout_ms;
  } status_t;

endpackage

@@ sv/letc_if.sv @@
// ----------------------------------------------------------------------------
// Lift end-stop controller channels
// Valid/ready channels for action items, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface letc_item_if;
  logic            valid;
  logic            ready;
  letc_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface letc_result_if;
  logic              valid;
  logic              ready;
  letc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface letc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic                              index;
  logic [letc_pkg::CfgDataW-1:0]     wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ sv/letc_in_stage.sv @@
// ----------------------------------------------------------------------------
// Lift end-stop controller input register
// Holds one accepted action item until the core consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module letc_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  letc_item_if.sink        item_i,
  input  logic             take_i,
  output logic             valid_o,
  output letc_pkg::item_t  data_o
);

  logic            valid_q, valid_d;
  letc_pkg::item_t data_q;
  logic            load;

  assign item_i.ready = !valid_q || take_i;
  assign load         = item_i.valid && item_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= item_i.data;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ sv/letc_core.sv @@
// ----------------------------------------------------------------------------
// Lift end-stop controller core
// Lift state, configuration registers and the per-action update logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module letc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  letc_cfg_if.sink           cfg_i,
  input  logic               fire_i,
  input  letc_pkg::item_t    item_i,
  output letc_pkg::result_t  result_o,
  output letc_pkg::status_t  status_o
);

  logic                               bel_q, bel_d;
  logic                               tgt_q, tgt_d;
  logic                               en_q, en_d;
  logic                               mov_q, mov_d;
  logic [letc_pkg::TimeW-1:0]         start_q, start_d;
  logic [letc_pkg::FailW-1:0]         fail_q, fail_d;
  logic [letc_pkg::DutyW-1:0]         duty_q;
  logic [letc_pkg::TimeoutW-1:0]      tmo_q;

  logic                               here;
  logic [letc_pkg::TimeW-1:0]         elapsed;
  logic                               in_time;
  letc_pkg::cmd_e                     cmd;
  logic                               dir;
  logic [letc_pkg::DutyW-1:0]         duty;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= letc_pkg::DutyReset;
      tmo_q  <= letc_pkg::TimeoutReset;
    end else if (cfg_i.valid) begin
      unique case (letc_pkg::cfg_idx_e'(cfg_i.index))
        letc_pkg::CFG_DUTY:    duty_q <= cfg_i.wdata[letc_pkg::DutyW-1:0];
        letc_pkg::CFG_TIMEOUT: tmo_q  <= cfg_i.wdata[letc_pkg::TimeoutW-1:0];
        default:               duty_q <= duty_q;
      endcase
    end
  end

  assign here    = (tgt_q == letc_pkg::POS_UP) ? item_i.up_contact : item_i.down_contact;
  assign elapsed = item_i.now_ms - start_q;
  assign in_time = elapsed < {{(letc_pkg::TimeW-letc_pkg::TimeoutW){1'b0}}, tmo_q};

  always_comb begin
    bel_d   = bel_q;
    tgt_d   = tgt_q;
    en_d    = en_q;
    mov_d   = mov_q;
    start_d = start_q;
    fail_d  = fail_q;
    cmd     = letc_pkg::CMD_NONE;
    dir     = 1'b0;
    duty    = '0;
    unique case (letc_pkg::act_e'(item_i.action))
      letc_pkg::ACT_MOVE: begin
        tgt_d   = item_i.target;
        en_d    = 1'b1;
        mov_d   = 1'b1;
        start_d = item_i.now_ms;
      end
      letc_pkg::ACT_CLEAR: begin
        fail_d = '0;
      end
      letc_pkg::ACT_ENABLE: begin
        en_d = item_i.enable;
      end
      letc_pkg::ACT_STEP: begin
        if (en_q && (fail_q < letc_pkg::FailLimit)) begin
          if (!here && (bel_q != tgt_q)) begin
            if (in_time) begin
              cmd  = letc_pkg::CMD_RUN;
              dir  = tgt_q;
              duty = duty_q;
            end else begin
              // count the failure and head back toward the other end
              bel_d   = tgt_q;
              fail_d  = fail_q + letc_pkg::FailW'(1);
              tgt_d   = !tgt_q;
              en_d    = 1'b1;
              mov_d   = 1'b1;
              start_d = item_i.now_ms;
              cmd     = letc_pkg::CMD_STOP;
            end
          end else if (here) begin
            if (tgt_q == letc_pkg::POS_UP) begin
              bel_d = letc_pkg::POS_UP;
              if (mov_q) begin
                // top reached: stop and send the lift back down
                tgt_d   = letc_pkg::POS_DOWN;
                en_d    = 1'b1;
                mov_d   = 1'b1;
                start_d = item_i.now_ms;
                cmd     = letc_pkg::CMD_STOP;
              end
            end else begin
              bel_d = letc_pkg::POS_DOWN;
              mov_d = 1'b0;
              en_d  = 1'b0;
              cmd   = letc_pkg::CMD_STOP;
            end
          end
        end else begin
          bel_d = tgt_q;
          mov_d = 1'b0;
          en_d  = 1'b0;
          cmd   = letc_pkg::CMD_STOP;
        end
      end
      default: begin
        cmd = letc_pkg::CMD_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bel_q   <= letc_pkg::POS_UP;
      tgt_q   <= letc_pkg::POS_DOWN;
      en_q    <= 1'b1;
      mov_q   <= 1'b1;
      start_q <= '0;
      fail_q  <= '0;
    end else if (fire_i) begin
      bel_q   <= bel_d;
      tgt_q   <= tgt_d;
      en_q    <= en_d;
      mov_q   <= mov_d;
      start_q <= start_d;
      fail_q  <= fail_d;
    end
  end

  always_comb begin
    result_o.motor_command   = cmd;
    result_o.motor_direction = dir;
    result_o.motor_duty      = duty;
    result_o.lift_position   = bel_d;
    result_o.is_moving       = mov_d;
    result_o.control_on      = en_d;
    result_o.failure_count   = fail_d;
  end

  assign status_o.duty_level = duty_q;
  assign status_o.timeout_ms = tmo_q;

endmodule

@@ sv/letc_out_stage.sv @@
// ----------------------------------------------------------------------------
// Lift end-stop controller result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module letc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  letc_pkg::result_t  data_i,
  output logic               ready_o,
  letc_result_if.source      result_o
);

  logic              valid_q, valid_d;
  letc_pkg::result_t data_q;

  assign ready_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign result_o.valid = valid_q;
  assign result_o.data  = data_q;

endmodule

@@ sv/lift_endstop_timeout_controller.sv @@
// ----------------------------------------------------------------------------
// Lift end-stop timeout controller
// Two-position lift control with end switches, move timeout and failure block.
// ----------------------------------------------------------------------------
// Each action item yields exactly one result: the item is held in the input
// register, then the state update and the result are computed in one pass
// (a 32-bit elapsed-time subtract and compare) into the result register.
// A new item is accepted every cycle as long as results are taken; a stalled
// result holds both registers. Register writes are taken at any time and
// must only be issued while no item is in flight.
`timescale 1ns / 1ps
`include "lift_endstop_timeout_controller_defines.svh"

module lift_endstop_timeout_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  letc_cfg_if.sink       cfg_i,
  letc_item_if.sink      item_i,
  letc_result_if.source  result_o
);

  logic              in_valid;
  letc_pkg::item_t   in_data;
  logic              out_ready;
  logic              fire;
  letc_pkg::result_t core_result;
  letc_pkg::status_t status;

  // advance the held item when the result register can take it
  assign fire = in_valid && out_ready;

  letc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .take_i  (out_ready),
    .valid_o (in_valid),
    .data_o  (in_data)
  );

  letc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .fire_i   (fire),
    .item_i   (in_data),
    .result_o (core_result),
    .status_o (status)
  );

  letc_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .data_i   (core_result),
    .ready_o  (out_ready),
    .result_o (result_o)
  );

  `LETC_ASSERT_IMPLIES(a_fail_bounded, result_o.valid, result_o.data.failure_count <= letc_pkg::FailLimit, "failure count above limit")
  `LETC_ASSERT_IMPLIES(a_run_allowed, result_o.valid && (result_o.data.motor_command == letc_pkg::CMD_RUN), result_o.data.control_on && (result_o.data.failure_count < letc_pkg::FailLimit), "run issued while control blocked")
  `LETC_ASSERT_IMPLIES(a_run_duty, result_o.valid && (result_o.data.motor_command == letc_pkg::CMD_RUN), result_o.data.motor_duty == status.duty_level, "run duty differs from configured duty")
  `LETC_ASSERT_NEXT(a_fire_loads, fire, result_o.valid, "advanced item did not reach result register")

endmodule
